// ----- src/mtc_pkg.sv -----
`timescale 1ns / 1ps

package mtc_pkg;

  // Default alphabet size for the two-letter node names.
  localparam int LETTERS_DEF = 26;

  // Fixed field widths.
  localparam int LETTER_W = 5;
  localparam int COUNT_W  = 26;

  // Adjacency rows are stored as words of this many bits.
  localparam int WORD_BITS = 32;
  localparam int BIT_W     = $clog2(WORD_BITS);

  // Reset value of the mark letter ('t').
  localparam logic [LETTER_W-1:0] MARK_RESET = LETTER_W'(19);

  // Saturation limit of the triangle count.
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Control of the word accumulator, issued together with the memory reads.
  typedef struct packed {
    logic clear;  // zero the running total before a count
    logic en;     // a word pair is being read this cycle
  } mtc_acc_ctl_t;

  // Population count of one word: nibble counts, then a short sum.
  function automatic logic [BIT_W:0] pop_word(input logic [WORD_BITS-1:0] x);
    logic [2:0]     nib [WORD_BITS/4];
    logic [BIT_W:0] sum;
    for (int n = 0; n < WORD_BITS / 4; n++) begin
      nib[n] = 3'(x[4*n]) + 3'(x[4*n+1]) + 3'(x[4*n+2]) + 3'(x[4*n+3]);
    end
    sum = '0;
    for (int n = 0; n < WORD_BITS / 4; n++) begin
      sum = sum + (BIT_W + 1)'(nib[n]);
    end
    return sum;
  endfunction

endpackage

// ----- src/mtc_adj_mem.sv -----
`timescale 1ns / 1ps

module mtc_adj_mem #(
  parameter int NODE_W = 10,
  parameter int WIDX_W = 5,
  parameter int NODES  = 676
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [NODE_W+WIDX_W-1:0]               waddr,
  input  logic [mtc_pkg::WORD_BITS-1:0]          wdata,
  input  logic [NODE_W+WIDX_W-1:0]               raddr_a,
  input  logic [NODE_W+WIDX_W-1:0]               raddr_b,
  output logic [mtc_pkg::WORD_BITS-1:0]          rdata_a,
  output logic [mtc_pkg::WORD_BITS-1:0]          rdata_b
);
  import mtc_pkg::*;

  localparam int DEPTH = NODES << WIDX_W;

  logic [WORD_BITS-1:0] mem_r [DEPTH];
  logic [WORD_BITS-1:0] rdata_a_r;
  logic [WORD_BITS-1:0] rdata_b_r;

  // One write port and two registered read ports.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a_r <= mem_r[raddr_a];
    rdata_b_r <= mem_r[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// ----- src/mtc_word_count.sv -----
`timescale 1ns / 1ps

module mtc_word_count #(
  parameter int LETTERS = 26,
  parameter int NODE_W  = 10,
  parameter int WIDX_W  = 5
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  mtc_pkg::mtc_acc_ctl_t                ctl,
  input  logic [NODE_W-1:0]                    node_i,
  input  logic [NODE_W-1:0]                    node_j,
  input  logic [WIDX_W-1:0]                    word_idx,
  input  logic [mtc_pkg::LETTER_W-1:0]         mark_letter,
  input  logic [mtc_pkg::WORD_BITS-1:0]        rdata_a,
  input  logic [mtc_pkg::WORD_BITS-1:0]        rdata_b,
  output logic [mtc_pkg::COUNT_W-1:0]          count,
  output logic                                 busy
);
  import mtc_pkg::*;

  // Comparison width covers both mark bounds and every bit position of a row.
  localparam int MK_W  = $clog2(32 * LETTERS) + 1;
  localparam int POS_W = WIDX_W + BIT_W;
  localparam int CMP_W = (MK_W > POS_W) ? MK_W : POS_W;

  logic                 en_d_r;
  logic [NODE_W-1:0]    node_i_d_r;
  logic [NODE_W-1:0]    node_j_d_r;
  logic [WIDX_W-1:0]    word_d_r;
  logic [WORD_BITS-1:0] x_r;
  logic [WORD_BITS-1:0] x_nxt;
  logic                 x_valid_r;
  logic [COUNT_W-1:0]   acc_r;
  logic [COUNT_W-1:0]   acc_nxt;

  logic [CMP_W-1:0]     mark_lo;
  logic [CMP_W-1:0]     mark_hi;
  logic [WORD_BITS-1:0] marked;
  logic [WORD_BITS-1:0] above_j;
  logic [WORD_BITS:0]   low_mask;
  logic                 pair_marked;
  logic [BIT_W-1:0]     j_bit;
  logic [COUNT_W:0]     sum;

  // Marked nodes form one contiguous index range: mark*LETTERS upwards.
  assign mark_lo = CMP_W'(mark_letter) * CMP_W'(LETTERS);
  assign mark_hi = mark_lo + CMP_W'(LETTERS - 1);

  assign pair_marked = (CMP_W'(node_i_d_r) >= mark_lo && CMP_W'(node_i_d_r) <= mark_hi) ||
                       (CMP_W'(node_j_d_r) >= mark_lo && CMP_W'(node_j_d_r) <= mark_hi);
  assign j_bit       = BIT_W'(node_j_d_r);

  // Common neighbours above j, restricted to marked nodes when neither end is marked.
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      marked[b] = (CMP_W'({word_d_r, b[BIT_W-1:0]}) >= mark_lo) &&
                  (CMP_W'({word_d_r, b[BIT_W-1:0]}) <= mark_hi);
    end
    low_mask = ((WORD_BITS + 1)'(1) << ((BIT_W + 1)'(j_bit) + 1'b1)) - 1'b1;
    if (word_d_r == WIDX_W'(node_j_d_r >> BIT_W)) begin
      above_j = ~low_mask[WORD_BITS-1:0];
    end else begin
      above_j = '1;
    end
    x_nxt = rdata_a & rdata_b & above_j & (pair_marked ? '1 : marked);
  end

  // Saturating accumulation of the bit count of the staged word.
  always_comb begin
    sum = {1'b0, acc_r} + (COUNT_W + 1)'(pop_word(x_r));
    if (ctl.clear) begin
      acc_nxt = '0;
    end else if (x_valid_r) begin
      acc_nxt = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
    end else begin
      acc_nxt = acc_r;
    end
  end

  // Read-issue tag, staged word and running total.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_d_r    <= 1'b0;
      x_valid_r <= 1'b0;
    end else begin
      en_d_r    <= ctl.en;
      x_valid_r <= en_d_r;
    end
    node_i_d_r <= node_i;
    node_j_d_r <= node_j;
    word_d_r   <= word_idx;
    x_r        <= x_nxt;
    acc_r      <= acc_nxt;
  end

  assign count = acc_r;
  assign busy  = en_d_r | x_valid_r;

endmodule

// ----- src/marked_triangle_counter.sv -----
`timescale 1ns / 1ps
// Add transaction: accepted in ST_IDLE, then a read-modify-write on the adjacency memory
// (ST_ADD_RD, ST_ADD_WA, ST_ADD_WB); no result. The next transaction is taken back in ST_IDLE.
// Count transaction: ST_J_RD and ST_J_CHK for each node pair i<j, plus one ST_K_LOOP step
// per adjacency word from j's word to the row end for each edge, then ST_DONE to drain.
// Reset: a clearing pass writes every memory word, NODES times the row words rounded up to a
// power of two, input stalled; the mark letter resets to 't'.
module marked_triangle_counter #(
  parameter int LETTERS = mtc_pkg::LETTERS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_func,
  input  logic [mtc_pkg::LETTER_W-1:0]        in_first_node_high,
  input  logic [mtc_pkg::LETTER_W-1:0]        in_first_node_low,
  input  logic [mtc_pkg::LETTER_W-1:0]        in_second_node_high,
  input  logic [mtc_pkg::LETTER_W-1:0]        in_second_node_low,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mtc_pkg::COUNT_W-1:0]         out_triangle_count,
  input  logic                                cfg_we,
  input  logic [mtc_pkg::LETTER_W-1:0]        cfg_mark_letter
);
  import mtc_pkg::*;

  localparam int NODES  = LETTERS * LETTERS;
  localparam int NODE_W = $clog2(NODES);
  localparam int WORDS  = (NODES + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int ADDR_W = NODE_W + WIDX_W;
  localparam int DEPTH  = NODES << WIDX_W;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WA,
    ST_ADD_WB,
    ST_CNT_INIT,
    ST_J_RD,
    ST_J_CHK,
    ST_K_LOOP,
    ST_DONE
  } state_t;

  state_t               state_r, state_nxt;
  logic [ADDR_W-1:0]    clr_addr_r, clr_addr_nxt;
  logic [NODE_W-1:0]    node_a_r, node_a_nxt;
  logic [NODE_W-1:0]    node_b_r, node_b_nxt;
  logic [NODE_W-1:0]    i_r, i_nxt;
  logic [NODE_W-1:0]    j_r, j_nxt;
  logic [WIDX_W-1:0]    w_r, w_nxt;
  logic [LETTER_W-1:0]  mark_letter_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0]   out_count_r, out_count_nxt;

  logic                 in_acc;
  logic                 letters_ok;
  logic [NODE_W-1:0]    node_a_in;
  logic [NODE_W-1:0]    node_b_in;

  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [ADDR_W-1:0]    mem_raddr_a;
  logic [ADDR_W-1:0]    mem_raddr_b;
  logic [WORD_BITS-1:0] mem_rdata_a;
  logic [WORD_BITS-1:0] mem_rdata_b;

  mtc_acc_ctl_t         acc_ctl;
  logic [COUNT_W-1:0]   acc_count;
  logic                 acc_busy;

  // Input transactions are taken only between operations.
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // Endpoint indices of an add transaction and its range check.
  assign letters_ok = (int'(in_first_node_high) < LETTERS) && (int'(in_first_node_low) < LETTERS) &&
                      (int'(in_second_node_high) < LETTERS) &&
                      (int'(in_second_node_low) < LETTERS);
  assign node_a_in = NODE_W'(int'(in_first_node_high) * LETTERS + int'(in_first_node_low));
  assign node_b_in = NODE_W'(int'(in_second_node_high) * LETTERS + int'(in_second_node_low));

  // Memory port control for each phase.
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_raddr_a = '0;
    mem_raddr_b = '0;
    acc_ctl     = '0;
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
      end
      ST_ADD_RD: begin
        mem_raddr_a = {node_a_r, WIDX_W'(node_b_r >> BIT_W)};
        mem_raddr_b = {node_b_r, WIDX_W'(node_a_r >> BIT_W)};
      end
      ST_ADD_WA: begin
        // The second row's word is read again so that it is still there next cycle.
        mem_raddr_b = {node_b_r, WIDX_W'(node_a_r >> BIT_W)};
        mem_we      = 1'b1;
        mem_waddr   = {node_a_r, WIDX_W'(node_b_r >> BIT_W)};
        mem_wdata   = mem_rdata_a | (WORD_BITS'(1) << BIT_W'(node_b_r));
      end
      ST_ADD_WB: begin
        mem_we    = 1'b1;
        mem_waddr = {node_b_r, WIDX_W'(node_a_r >> BIT_W)};
        mem_wdata = mem_rdata_b | (WORD_BITS'(1) << BIT_W'(node_a_r));
      end
      ST_CNT_INIT: begin
        acc_ctl.clear = 1'b1;
      end
      ST_J_RD: begin
        mem_raddr_a = {i_r, WIDX_W'(j_r >> BIT_W)};
      end
      ST_K_LOOP: begin
        mem_raddr_a = {i_r, w_r};
        mem_raddr_b = {j_r, w_r};
        acc_ctl.en  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Sequencer: clearing pass, edge insertion and the pair and word scan.
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    node_a_nxt    = node_a_r;
    node_b_nxt    = node_b_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    w_nxt         = w_r;
    out_count_nxt = out_count_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          node_a_nxt = node_a_in;
          node_b_nxt = node_b_in;
          if (in_func) begin
            state_nxt = ST_CNT_INIT;
          end else if (letters_ok && node_a_in != node_b_in) begin
            state_nxt = ST_ADD_RD;
          end
        end
      end
      ST_ADD_RD: begin
        state_nxt = ST_ADD_WA;
      end
      ST_ADD_WA: begin
        state_nxt = ST_ADD_WB;
      end
      ST_ADD_WB: begin
        state_nxt = ST_IDLE;
      end
      ST_CNT_INIT: begin
        i_nxt     = '0;
        j_nxt     = NODE_W'(1);
        state_nxt = ST_J_RD;
      end
      ST_J_RD: begin
        state_nxt = ST_J_CHK;
      end
      ST_J_CHK, ST_K_LOOP: begin
        if (state_r == ST_J_CHK && mem_rdata_a[BIT_W'(j_r)]) begin
          // Edge i-j present: walk the words of both rows from j's word on.
          w_nxt     = WIDX_W'(j_r >> BIT_W);
          state_nxt = ST_K_LOOP;
        end else if (state_r == ST_K_LOOP && w_r != WIDX_W'(WORDS - 1)) begin
          w_nxt = w_r + 1'b1;
        end else if (j_r != NODE_W'(NODES - 1)) begin
          j_nxt     = j_r + 1'b1;
          state_nxt = ST_J_RD;
        end else if (i_r != NODE_W'(NODES - 2)) begin
          i_nxt     = i_r + 1'b1;
          j_nxt     = i_r + NODE_W'(2);
          state_nxt = ST_J_RD;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // Wait for the accumulator to drain and the output register to be free.
        if (!acc_busy && (!out_valid_r || !out_stall)) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = acc_count;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      clr_addr_r    <= '0;
      out_valid_r   <= 1'b0;
      mark_letter_r <= MARK_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        mark_letter_r <= cfg_mark_letter;
      end
    end
    node_a_r    <= node_a_nxt;
    node_b_r    <= node_b_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    w_r         <= w_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_triangle_count = out_count_r;

  mtc_adj_mem #(
    .NODE_W (NODE_W),
    .WIDX_W (WIDX_W),
    .NODES  (NODES)
  ) u_adj_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (mem_rdata_a),
    .rdata_b (mem_rdata_b)
  );

  mtc_word_count #(
    .LETTERS (LETTERS),
    .NODE_W  (NODE_W),
    .WIDX_W  (WIDX_W)
  ) u_word_count (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (acc_ctl),
    .node_i      (i_r),
    .node_j      (j_r),
    .word_idx    (w_r),
    .mark_letter (mark_letter_r),
    .rdata_a     (mem_rdata_a),
    .rdata_b     (mem_rdata_b),
    .count       (acc_count),
    .busy        (acc_busy)
  );

`ifndef SYNTH
  // A result only ever appears at the end of a count.
  a_result_from_count: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside the end of a count");

  // The scan only walks pairs with j above i.
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_K_LOOP || state_r == ST_J_CHK) |-> (j_r > i_r))
    else $error("pair scan left the upper triangle");

  // Self-edges never reach the memory.
  a_no_self_edge: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ADD_WA) |-> (node_a_r != node_b_r))
    else $error("self-edge written to adjacency memory");

  // The total is taken only after the last word has been summed.
  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && state_nxt == ST_IDLE) |=> (out_count_r == $past(acc_count)))
    else $error("count captured from a stale total");
`endif

endmodule
